// File: design/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define TCQ_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every rising edge, reset included
`define TCQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tcq_pkg.sv
// types and constants of the two-class oldest-first queue
`timescale 1ns / 1ps

package tcq_pkg;

    localparam int VALUE_W             = 32;
    localparam int SEQ_W               = 6;
    localparam int CHOICE_W            = 2;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    localparam logic [CHOICE_W-1:0] CHOICE_OLDEST = 2'd0;
    localparam logic [CHOICE_W-1:0] CHOICE_CLASS0 = 2'd1;
    localparam logic [CHOICE_W-1:0] CHOICE_CLASS1 = 2'd2;

    localparam logic CLASS_NONNEG = 1'b0;
    localparam logic CLASS_NEG    = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]          seq;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

// File: design/two_class_oldest_first_queue_unit.sv
// top level of the two-class oldest-first queue
`timescale 1ns / 1ps

`include "assert_macros.svh"

// channel  | ports                                        | role
// s_ (in)  | s_valid s_ready s_opcode s_item_value         | arrival or take request beat
//          | s_take_choice                                |
// m_ (out) | m_valid m_ready m_taken_value m_taken_class  | removed item beat
//
// one beat per cycle unless a take waits on a stalled result; a take result is registered
// after the input register; the rate is set by the fifo pointer update and front prefetch
// reset clears pointers, counts, sequence counter and both valid registers; stores are not
// cleared, only entries that were written are read
// a stalled result stops only takes that remove an item; arrivals and takes on an empty
// class keep flowing past a waiting result

module two_class_oldest_first_queue_unit #(
    parameter int QUEUE_DEPTH = tcq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic signed [tcq_pkg::VALUE_W-1:0] s_item_value,
    input  logic [tcq_pkg::CHOICE_W-1:0]       s_take_choice,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tcq_pkg::VALUE_W-1:0] m_taken_value,
    output logic                               m_taken_class
);

    // input register
    logic                               in_valid_reg;
    logic                               in_opcode_reg;
    logic signed [tcq_pkg::VALUE_W-1:0] in_value_reg;
    logic [tcq_pkg::CHOICE_W-1:0]       in_choice_reg;

    // sequence counter and result register
    logic [tcq_pkg::SEQ_W-1:0]          seq_reg, seq_next;
    logic                               m_valid_reg, m_valid_next;
    logic signed [tcq_pkg::VALUE_W-1:0] m_value_reg;
    logic                               m_class_reg;

    tcq_pkg::entry_t       front0, front1, push_entry;
    tcq_pkg::fifo_status_t st0, st1;

    logic                      out_free;
    logic                      take_hit;
    logic                      take_cls;
    logic                      proc_fire;
    logic                      push0, push1, pop0, pop1;
    logic [tcq_pkg::SEQ_W-1:0] age_diff;

    assign out_free = !m_valid_reg || m_ready;
    // positive distance from front 0 to front 1 means front 0 arrived first
    assign age_diff = front1.seq - front0.seq;

    // pick the class a take would remove from
    always_comb begin
        take_hit = 1'b0;
        take_cls = tcq_pkg::CLASS_NONNEG;
        unique case (in_choice_reg)
            tcq_pkg::CHOICE_OLDEST: begin
                priority if (!st0.empty && !st1.empty) begin
                    take_hit = 1'b1;
                    take_cls = age_diff[tcq_pkg::SEQ_W-1] ? tcq_pkg::CLASS_NEG
                                                          : tcq_pkg::CLASS_NONNEG;
                end else if (!st0.empty) begin
                    take_hit = 1'b1;
                    take_cls = tcq_pkg::CLASS_NONNEG;
                end else if (!st1.empty) begin
                    take_hit = 1'b1;
                    take_cls = tcq_pkg::CLASS_NEG;
                end else begin
                    take_hit = 1'b0;
                end
            end
            tcq_pkg::CHOICE_CLASS0: begin
                take_hit = !st0.empty;
                take_cls = tcq_pkg::CLASS_NONNEG;
            end
            default: begin
                // class 1 choice and the unused code both take from class 1
                take_hit = !st1.empty;
                take_cls = tcq_pkg::CLASS_NEG;
            end
        endcase
    end

    // a take that hits needs room in the result register, everything else goes through
    assign proc_fire = in_valid_reg &&
                       ((in_opcode_reg == tcq_pkg::OP_ARRIVE) || !take_hit || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;

    assign push0 = proc_fire && (in_opcode_reg == tcq_pkg::OP_ARRIVE) &&
                   !in_value_reg[tcq_pkg::VALUE_W-1] && !st0.full;
    assign push1 = proc_fire && (in_opcode_reg == tcq_pkg::OP_ARRIVE) &&
                   in_value_reg[tcq_pkg::VALUE_W-1] && !st1.full;
    assign pop0  = proc_fire && (in_opcode_reg == tcq_pkg::OP_TAKE) && take_hit &&
                   (take_cls == tcq_pkg::CLASS_NONNEG);
    assign pop1  = proc_fire && (in_opcode_reg == tcq_pkg::OP_TAKE) && take_hit &&
                   (take_cls == tcq_pkg::CLASS_NEG);

    assign push_entry.seq   = seq_reg;
    assign push_entry.value = in_value_reg;

    // dropped arrivals leave the counter alone
    assign seq_next = (push0 || push1) ? seq_reg + 1'b1 : seq_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop0 || pop1) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    tcq_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_class0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push0),
        .push_entry(push_entry),
        .pop       (pop0),
        .front     (front0),
        .status    (st0)
    );

    tcq_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_class1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push1),
        .push_entry(push_entry),
        .pop       (pop1),
        .front     (front1),
        .status    (st1)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            seq_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_value_reg  <= s_item_value;
            in_choice_reg <= s_take_choice;
        end
        if (pop0 || pop1) begin
            m_value_reg <= pop1 ? front1.value : front0.value;
            m_class_reg <= pop1 ? tcq_pkg::CLASS_NEG : tcq_pkg::CLASS_NONNEG;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_taken_value = m_value_reg;
    assign m_taken_class = m_class_reg;

    // a successful take always lands in the result register
    `TCQ_ASSERT(a_take_gives_beat, aclk, aresetn, (pop0 || pop1) |=> m_valid_reg, "take lost")
    // never remove from an empty class
    `TCQ_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop0 && st0.empty) && !(pop1 && st1.empty), "pop from empty class")
    // a held request keeps its opcode
    `TCQ_ASSERT(a_hold_request, aclk, aresetn, (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_opcode_reg)), "held request changed")
    // reset leaves no result pending
    `TCQ_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule

// File: design/tcq_fifo.sv
// one class fifo with a registered front entry
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tcq_fifo #(
    parameter int QUEUE_DEPTH = tcq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tcq_pkg::entry_t       push_entry,
    input  logic                  pop,
    output tcq_pkg::entry_t       front,
    output tcq_pkg::fifo_status_t status
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    tcq_pkg::entry_t mem [QUEUE_DEPTH];

    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    tcq_pkg::entry_t rd_data_reg;
    tcq_pkg::entry_t byp_data_reg;
    logic            byp_reg, byp_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        end
        if (push) begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
        // new front is being written right now
        byp_next = push && (tail_reg == head_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            byp_reg   <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_entry;
        end
        rd_data_reg  <= mem[head_next];
        byp_data_reg <= push_entry;
    end

    assign front        = byp_reg ? byp_data_reg : rd_data_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FULL_COUNT);

endmodule
